FILE: hdl/cfd_pkg.sv
package cfd_pkg;

    localparam int SIZE_W = 17;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;
    localparam logic [SIZE_W-1:0] OVERHEAD_BYTES = 17'd4;
    localparam logic [SIZE_W-1:0] MAX_FRAME_RESET = 17'd100;

    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 2'd2;

    // One registered received byte handed from the input stage to the engine
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } stage_t;

    // One result item
    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   body_byte;
        logic                is_opcode;
        logic [STATUS_W-1:0] frame_status;
        logic [SIZE_W-1:0]   frame_size;
    } item_t;

endpackage

FILE: hdl/cfd_byte_if.sv
interface cfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [cfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/cfd_item_if.sv
interface cfd_item_if;
    logic                         valid;
    logic                         ready;
    logic                         item_kind;
    logic [cfd_pkg::BYTE_W-1:0]   body_byte;
    logic                         is_opcode;
    logic [cfd_pkg::STATUS_W-1:0] frame_status;
    logic [cfd_pkg::SIZE_W-1:0]   frame_size;

    modport source (output valid, output item_kind, output body_byte, output is_opcode,
                    output frame_status, output frame_size, input ready);
    modport sink (input valid, input item_kind, input body_byte, input is_opcode,
                  input frame_status, input frame_size, output ready);
endinterface

FILE: hdl/cfd_in_stage.sv
module cfd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    cfd_byte_if.sink        in_bytes,
    input  logic            take,
    output cfd_pkg::stage_t stage
);

    logic                       vld_reg;
    logic                       vld_next;
    logic [cfd_pkg::BYTE_W-1:0] byte_reg;
    logic [cfd_pkg::BYTE_W-1:0] byte_next;
    logic                       accept;

    // Accept a new request when the register is empty or drains this cycle
    assign in_bytes.ready = !vld_reg || take;
    assign accept = in_bytes.valid && in_bytes.ready;

    always_comb
    begin
        vld_next = vld_reg;
        byte_next = byte_reg;
        if (accept)
        begin
            vld_next = 1'b1;
            byte_next = in_bytes.rx_byte;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the byte payload; no reset needed
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign stage.valid = vld_reg;
    assign stage.rx_byte = byte_reg;

endmodule

FILE: hdl/cfd_engine.sv
module cfd_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cfd_pkg::SIZE_W-1:0] cfg_wdata,
    input  cfd_pkg::stage_t            stage,
    output logic                       take,
    cfd_item_if.source                 out_items
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CHECK,
        PH_SWALLOW
    } phase_t;

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [cfd_pkg::SIZE_W-1:0]   expected_size_reg;
    logic [cfd_pkg::SIZE_W-1:0]   expected_size_next;
    logic [cfd_pkg::SIZE_W-1:0]   bytes_seen_reg;
    logic [cfd_pkg::SIZE_W-1:0]   bytes_seen_next;
    logic [cfd_pkg::BYTE_W-1:0]   running_sum_reg;
    logic [cfd_pkg::BYTE_W-1:0]   running_sum_next;
    logic [cfd_pkg::SIZE_W-1:0]   max_frame_reg;
    logic [cfd_pkg::SIZE_W-1:0]   max_frame_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    cfd_pkg::item_t               out_reg;
    cfd_pkg::item_t               out_next;

    logic                         room;
    logic [cfd_pkg::BYTE_W-1:0]   b;
    logic [cfd_pkg::BYTE_W-1:0]   sum_add;
    logic [cfd_pkg::SIZE_W-1:0]   bytes_inc;
    logic [cfd_pkg::SIZE_W-1:0]   len_size;
    logic                         body_last;
    logic                         emit;
    cfd_pkg::item_t               item;

    // Take a byte when the result register is free or drains this cycle
    assign room = !out_vld_reg || out_items.ready;
    assign take = stage.valid && room;

    assign b = stage.rx_byte;
    assign sum_add = running_sum_reg + b;
    assign bytes_inc = bytes_seen_reg + 17'd1;
    assign len_size = {1'b0, expected_size_reg[15:8], b} + cfd_pkg::OVERHEAD_BYTES;
    assign body_last = ({1'b0, bytes_inc} + 18'd1) >= {1'b0, expected_size_reg};

    // Advance the frame state for one byte and build its result
    always_comb
    begin
        phase_next = phase_reg;
        expected_size_next = expected_size_reg;
        bytes_seen_next = bytes_seen_reg;
        running_sum_next = running_sum_reg;
        emit = 1'b0;
        item = '0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                expected_size_next = {1'b0, b, 8'd0};
                running_sum_next = b;
                bytes_seen_next = 17'd2;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                expected_size_next = len_size;
                running_sum_next = sum_add;
                bytes_seen_next = 17'd3;
                if (len_size > max_frame_reg)
                begin
                    phase_next = PH_SWALLOW;
                end
                else if (len_size == cfd_pkg::OVERHEAD_BYTES)
                begin
                    phase_next = PH_CHECK;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                running_sum_next = sum_add;
                bytes_seen_next = bytes_inc;
                if (body_last)
                begin
                    phase_next = PH_CHECK;
                end
                emit = 1'b1;
                item.item_kind = cfd_pkg::KIND_BODY;
                item.body_byte = b;
                item.is_opcode = (bytes_seen_reg == 17'd3);
            end
            PH_CHECK:
            begin
                running_sum_next = sum_add;
                bytes_seen_next = bytes_inc;
                phase_next = PH_HUNT;
                emit = 1'b1;
                item.item_kind = cfd_pkg::KIND_END;
                item.frame_status = (sum_add == '0) ? cfd_pkg::STATUS_OK
                                                    : cfd_pkg::STATUS_BAD_SUM;
                item.frame_size = expected_size_reg;
            end
            PH_SWALLOW:
            begin
                bytes_seen_next = bytes_inc;
                if (bytes_inc >= expected_size_reg)
                begin
                    phase_next = PH_HUNT;
                    emit = 1'b1;
                    item.item_kind = cfd_pkg::KIND_END;
                    item.frame_status = cfd_pkg::STATUS_OVERSIZE;
                    item.frame_size = expected_size_reg;
                end
            end
            default:
            begin
                if (b == cfd_pkg::START_BYTE)
                begin
                    phase_next = PH_LEN_HI;
                    bytes_seen_next = 17'd1;
                    running_sum_next = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // Select what each register loads this cycle
    always_comb
    begin
        max_frame_next = cfg_we ? cfg_wdata : max_frame_reg;
        out_vld_next = out_vld_reg;
        out_next = out_reg;
        if (out_items.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (take && emit)
        begin
            out_vld_next = 1'b1;
            out_next = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            expected_size_reg <= '0;
            bytes_seen_reg <= '0;
            running_sum_reg <= '0;
            max_frame_reg <= cfd_pkg::MAX_FRAME_RESET;
            out_vld_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                expected_size_reg <= expected_size_next;
                bytes_seen_reg <= bytes_seen_next;
                running_sum_reg <= running_sum_next;
            end
            max_frame_reg <= max_frame_next;
            out_vld_reg <= out_vld_next;
            out_reg <= out_next;
        end
    end

    assign out_items.valid = out_vld_reg;
    assign out_items.item_kind = out_reg.item_kind;
    assign out_items.body_byte = out_reg.body_byte;
    assign out_items.is_opcode = out_reg.is_opcode;
    assign out_items.frame_status = out_reg.frame_status;
    assign out_items.frame_size = out_reg.frame_size;

endmodule

FILE: hdl/command_frame_deframer_core.sv
// Deframes length-prefixed command frames from a byte stream: bytes are dropped until the
// start byte 0xAA, then a big-endian 16-bit length, the body (opcode first) and a checksum
// byte follow. Each body byte of a frame within the size limit leaves as one item, and one
// end item per frame gives the status (ok, bad checksum, oversize) and the total size,
// length plus 4. Frames larger than cfg_wdata (written with cfg_we while idle, reset 100)
// are swallowed and end as oversize. One byte is taken every cycle while the result side
// keeps up; a byte passes an input register and the frame engine, and its result is held
// in the output register until it is taken.

module command_frame_deframer_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cfd_pkg::SIZE_W-1:0] cfg_wdata,
    cfd_byte_if.sink                   in_bytes,
    cfd_item_if.source                 out_items
);

    cfd_pkg::stage_t stage;
    logic            take;

    cfd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .take     (take),
        .stage    (stage)
    );

    cfd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .take      (take),
        .out_items (out_items)
    );

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    // Deframer position as tracked by the predictor
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CHECK,
        PH_SWALLOW
    } deframe_phase_e;

    typedef logic [cfd_pkg::BYTE_W-1:0] byte_q [$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [cfd_pkg::SIZE_W-1:0] cfg_wdata;

    cfd_byte_if in_bytes ();
    cfd_item_if out_items ();

    command_frame_deframer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_bytes(in_bytes),
        .out_items(out_items)
    );

    // Predictor state and the items it says are still to come
    deframe_phase_e link_phase = PH_HUNT;
    logic [cfd_pkg::SIZE_W-1:0] size_due = '0;
    logic [cfd_pkg::SIZE_W-1:0] seen_count = '0;
    logic [cfd_pkg::BYTE_W-1:0] frame_sum = '0;
    logic [cfd_pkg::SIZE_W-1:0] max_frame = cfd_pkg::MAX_FRAME_RESET;
    cfd_pkg::item_t frame_items_due [$];

    int in_idle_pct = 33;
    int out_idle_pct = 33;
    int hold_left = 0;
    int bytes_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Advance the predictor by one accepted byte
    function automatic void deframe_byte(input logic [cfd_pkg::BYTE_W-1:0] b);
        cfd_pkg::item_t it;
        it = '0;
        case (link_phase)
            PH_LEN_HI:
            begin
                size_due = {1'b0, b, 8'h00};
                frame_sum = b;
                seen_count = 17'd2;
                link_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                size_due = (size_due | {9'd0, b}) + cfd_pkg::OVERHEAD_BYTES;
                frame_sum = frame_sum + b;
                seen_count = 17'd3;
                if (size_due > max_frame)
                    link_phase = PH_SWALLOW;
                else if (size_due == cfd_pkg::OVERHEAD_BYTES)
                    link_phase = PH_CHECK;
                else
                    link_phase = PH_BODY;
            end
            PH_BODY:
            begin
                it.item_kind = cfd_pkg::KIND_BODY;
                it.body_byte = b;
                it.is_opcode = (seen_count == 17'd3);
                frame_sum = frame_sum + b;
                seen_count = seen_count + 17'd1;
                if (int'(seen_count) + 1 >= int'(size_due))
                    link_phase = PH_CHECK;
                frame_items_due.push_back(it);
            end
            PH_CHECK:
            begin
                frame_sum = frame_sum + b;
                seen_count = seen_count + 17'd1;
                it.item_kind = cfd_pkg::KIND_END;
                it.frame_status = (frame_sum == 8'h00) ? cfd_pkg::STATUS_OK
                                                       : cfd_pkg::STATUS_BAD_SUM;
                it.frame_size = size_due;
                frame_items_due.push_back(it);
                link_phase = PH_HUNT;
            end
            PH_SWALLOW:
            begin
                seen_count = seen_count + 17'd1;
                if (seen_count >= size_due)
                begin
                    it.item_kind = cfd_pkg::KIND_END;
                    it.frame_status = cfd_pkg::STATUS_OVERSIZE;
                    it.frame_size = size_due;
                    frame_items_due.push_back(it);
                    link_phase = PH_HUNT;
                end
            end
            default:
            begin
                if (b == cfd_pkg::START_BYTE)
                begin
                    link_phase = PH_LEN_HI;
                    seen_count = 17'd1;
                    frame_sum = 8'h00;
                end
                else
                    link_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive result ready: a long hold when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_items.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_items.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Check each delivered result against the oldest prediction
    always @(posedge clk)
    begin
        cfd_pkg::item_t got;
        cfd_pkg::item_t want;
        if (rst_n && out_items.valid && out_items.ready)
        begin
            got.item_kind = out_items.item_kind;
            got.body_byte = out_items.body_byte;
            got.is_opcode = out_items.is_opcode;
            got.frame_status = out_items.frame_status;
            got.frame_size = out_items.frame_size;
            if (frame_items_due.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: kind %0d byte %h op %0d status %0d size %0d",
                             got.item_kind, got.body_byte, got.is_opcode, got.frame_status,
                             got.frame_size);
                mismatches++;
            end
            else
            begin
                want = frame_items_due.pop_front();
                if (got.item_kind !== want.item_kind || got.body_byte !== want.body_byte ||
                    got.is_opcode !== want.is_opcode ||
                    got.frame_status !== want.frame_status ||
                    got.frame_size !== want.frame_size)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display({"result mismatch: expected kind %0d byte %h op %0d ",
                                  "status %0d size %0d, got kind %0d byte %h op %0d ",
                                  "status %0d size %0d"},
                                 want.item_kind, want.body_byte, want.is_opcode,
                                 want.frame_status, want.frame_size, got.item_kind,
                                 got.body_byte, got.is_opcode, got.frame_status,
                                 got.frame_size);
                    mismatches++;
                end
            end
        end
    end

    // Offer one byte, hold it until taken, then predict its effect
    task automatic send_byte(input logic [cfd_pkg::BYTE_W-1:0] b);
        @(negedge clk);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_bytes.valid <= 1'b0;
            @(negedge clk);
        end
        in_bytes.valid <= 1'b1;
        in_bytes.rx_byte <= b;
        @(posedge clk);
        while (!in_bytes.ready)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b);
    endtask

    function automatic logic [cfd_pkg::BYTE_W-1:0] noise_byte();
        int v;
        v = $urandom_range(0, 254);
        if (v >= int'(cfd_pkg::START_BYTE))
            v++;
        return v[cfd_pkg::BYTE_W-1:0];
    endfunction

    task automatic send_noise(input int n);
        repeat (n)
            send_byte(noise_byte());
    endtask

    // Send start, length, body and checksum; optionally spoil the checksum
    task automatic send_frame(input byte_q body, input bit bad_sum);
        logic [15:0] len;
        logic [cfd_pkg::BYTE_W-1:0] chk;
        len = 16'(body.size());
        chk = len[15:8] + len[7:0];
        send_byte(cfd_pkg::START_BYTE);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        foreach (body[i])
        begin
            send_byte(body[i]);
            chk = chk + body[i];
        end
        chk = 8'h00 - chk;
        if (bad_sum)
            chk = chk + 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Start a frame, break it off early, then fill until hunting again
    task automatic send_cut_frame();
        int len;
        len = $urandom_range(2, 12);
        send_byte(cfd_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(8'(len));
        repeat ($urandom_range(0, len - 1))
            send_byte(8'($urandom_range(0, 255)));
        while (link_phase != PH_HUNT)
            send_byte(noise_byte());
    endtask

    function automatic byte_q random_body(input int len);
        byte_q body;
        repeat (len)
            body.push_back(8'($urandom_range(0, 255)));
        return body;
    endfunction

    // Mostly small bodies, some around the size limit
    function automatic int pick_length();
        int bound;
        int pick;
        bound = int'(max_frame) - 4;
        pick = $urandom_range(99);
        if (pick < 20 && bound >= 1 && bound <= 60)
            return bound - 1 + $urandom_range(0, 2);
        if (pick < 35)
            return $urandom_range(13, 40);
        return $urandom_range(0, 12);
    endfunction

    // Drop valid and let every predicted result drain
    task automatic wait_drained();
        @(negedge clk);
        in_bytes.valid <= 1'b0;
        while (frame_items_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_max_frame(input logic [cfd_pkg::SIZE_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        max_frame = value;
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame(random_body(pick_length()), $urandom_range(99) < 20);
            else if (pick < 88)
                send_noise($urandom_range(1, 3));
            else
                send_cut_frame();
        end
    endtask

    // Noise, empty body, start byte in the body, exact fit, small maximum
    task automatic test_directed();
        byte_q body;
        send_byte(8'h00);
        send_byte(8'hFF);
        body.delete();
        send_frame(body, 1'b0);
        body = '{cfd_pkg::START_BYTE, 8'h55};
        send_frame(body, 1'b1);
        write_max_frame(17'd5);
        body = '{8'h7E};
        send_frame(body, 1'b0);
        body = '{8'h01, 8'h02};
        send_frame(body, 1'b0);
        write_max_frame(17'd0);
        body.delete();
        send_frame(body, 1'b0);
    endtask

    // Random traffic under a range of size limits
    task automatic test_random_limits();
        logic [cfd_pkg::SIZE_W-1:0] limits [8];
        limits = '{17'd100, 17'd4, 17'd5, 17'd0, 17'd3, 17'd20, 17'h1FFFF, 17'd65539};
        foreach (limits[i])
        begin
            write_max_frame(limits[i]);
            run_random(140);
        end
    endtask

    // Back to back traffic with neither side idling
    task automatic test_no_idle();
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_max_frame(17'd24);
        run_random(150);
        wait_drained();
        in_idle_pct = 33;
        out_idle_pct = 33;
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_backpressure();
        write_max_frame(17'h1FFFF);
        @(posedge clk);
        hold_left = 300;
        repeat (3)
            send_frame(random_body(40), 1'b0);
        wait_drained();
    endtask

    // Frames with a nonzero length high byte: an exact fit, then one byte over
    task automatic test_long_frames();
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_max_frame(17'd261);
        send_frame(random_body(257), 1'b0);
        send_frame(random_body(258), 1'b0);
        wait_drained();
        in_idle_pct = 33;
        out_idle_pct = 33;
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_bytes.valid = 1'b0;
        in_bytes.rx_byte = '0;
        out_items.ready = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_limits();
        test_no_idle();
        test_backpressure();
        test_long_frames();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
